FILE: rtl/core/segint_pkg.sv
// shared types, widths and helper functions for the segment intersection block
`default_nettype none
package segint_pkg;

  // coordinate width and the widths that follow from it
  localparam int CW   = 16;
  localparam int AW   = CW + 1;         // line coefficients a, b
  localparam int CPW  = 2 * CW + 1;     // line coefficient c
  localparam int DENW = 2 * AW + 1;     // determinant
  localparam int PW   = AW + CPW;       // numerator partial products
  localparam int NUMW = PW + 1;         // numerators
  localparam int QB   = CW + 1;         // quotient magnitude bits
  localparam int RW   = DENW + 1;       // divider remainder
  localparam int BW   = CW + 2;         // signed width for box compares
  localparam int TOLW = 8;
  localparam logic [TOLW-1:0] TOL_RESET = TOLW'(1);

  typedef struct packed {
    logic signed [CW-1:0] first_start_x;
    logic signed [CW-1:0] first_start_y;
    logic signed [CW-1:0] first_end_x;
    logic signed [CW-1:0] first_end_y;
    logic signed [CW-1:0] second_start_x;
    logic signed [CW-1:0] second_start_y;
    logic signed [CW-1:0] second_end_x;
    logic signed [CW-1:0] second_end_y;
  } in_t;

  typedef struct packed {
    logic                 hit;
    logic signed [CW-1:0] cross_x;
    logic signed [CW-1:0] cross_y;
  } out_t;

  // bounding boxes of both segments
  typedef struct packed {
    logic signed [CW-1:0] x1lo;
    logic signed [CW-1:0] x1hi;
    logic signed [CW-1:0] y1lo;
    logic signed [CW-1:0] y1hi;
    logic signed [CW-1:0] x2lo;
    logic signed [CW-1:0] x2hi;
    logic signed [CW-1:0] y2lo;
    logic signed [CW-1:0] y2hi;
  } box_t;

  // one stage of the two bit-serial dividers plus what rides along
  typedef struct packed {
    logic [RW-1:0]   rx;
    logic [RW-1:0]   ry;
    logic [QB-1:0]   lx;
    logic [QB-1:0]   ly;
    logic [QB-1:0]   qx;
    logic [QB-1:0]   qy;
    logic [DENW-1:0] ud;
    logic            negx;
    logic            negy;
    logic            bad;
    box_t            box;
  } dstage_t;

  // one restoring division step for both quotients
  function automatic dstage_t div_step(dstage_t d);
    dstage_t o;
    logic [RW-1:0] sx;
    logic [RW-1:0] sy;
    o  = d;
    sx = {d.rx[RW-2:0], d.lx[QB-1]};
    sy = {d.ry[RW-2:0], d.ly[QB-1]};
    o.lx = {d.lx[QB-2:0], 1'b0};
    o.ly = {d.ly[QB-2:0], 1'b0};
    if (sx >= RW'(d.ud)) begin
      o.rx = sx - RW'(d.ud);
      o.qx = {d.qx[QB-2:0], 1'b1};
    end else begin
      o.rx = sx;
      o.qx = {d.qx[QB-2:0], 1'b0};
    end
    if (sy >= RW'(d.ud)) begin
      o.ry = sy - RW'(d.ud);
      o.qy = {d.qy[QB-2:0], 1'b1};
    end else begin
      o.ry = sy;
      o.qy = {d.qy[QB-2:0], 1'b0};
    end
    return o;
  endfunction

  // point coordinate inside [lo - tol, hi + tol]
  function automatic logic in_span(logic signed [BW-1:0] q, logic signed [CW-1:0] lo,
                                   logic signed [CW-1:0] hi, logic [TOLW-1:0] tol);
    logic signed [BW-1:0] l;
    logic signed [BW-1:0] h;
    l = BW'(lo) - $signed(BW'(tol));
    h = BW'(hi) + $signed(BW'(tol));
    return (q >= l) && (q <= h);
  endfunction

endpackage
`default_nettype wire

FILE: rtl/core/segment_intersection.sv
// segment intersection top level: coefficient, product and divider pipeline
// pipeline: 7 front stages, 17 one-bit divider stages, a sign fix stage and the
//   output register
// throughput: one item per cycle; the whole pipeline holds while a result waits
// reset: synchronous rst clears all valid bits and sets tolerance to 1
`default_nettype none
module segment_intersection import segint_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_we,
  input  logic [TOLW-1:0] cfg_wdata,
  input  logic            in_valid,
  output logic            in_ready,
  input  in_t             in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output out_t            out_data
);

  logic [TOLW-1:0] tolerance;
  logic en;

  // pipeline advances unless a finished result is stalled
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  // tolerance register
  always_ff @(posedge clk) begin
    if (rst) begin
      tolerance <= TOL_RESET;
    end else if (cfg_we) begin
      tolerance <= cfg_wdata;
    end
  end

  // stage 1: coefficients a, b and bounding boxes
  logic v1;
  in_t p1;
  logic signed [AW-1:0] a1_1, b1_1, a2_1, b2_1;
  box_t box1;
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      p1   <= in_data;
      a1_1 <= AW'(in_data.first_end_y) - AW'(in_data.first_start_y);
      b1_1 <= AW'(in_data.first_start_x) - AW'(in_data.first_end_x);
      a2_1 <= AW'(in_data.second_end_y) - AW'(in_data.second_start_y);
      b2_1 <= AW'(in_data.second_start_x) - AW'(in_data.second_end_x);
      box1.x1lo <= (in_data.first_start_x < in_data.first_end_x) ?
                   in_data.first_start_x : in_data.first_end_x;
      box1.x1hi <= (in_data.first_start_x < in_data.first_end_x) ?
                   in_data.first_end_x : in_data.first_start_x;
      box1.y1lo <= (in_data.first_start_y < in_data.first_end_y) ?
                   in_data.first_start_y : in_data.first_end_y;
      box1.y1hi <= (in_data.first_start_y < in_data.first_end_y) ?
                   in_data.first_end_y : in_data.first_start_y;
      box1.x2lo <= (in_data.second_start_x < in_data.second_end_x) ?
                   in_data.second_start_x : in_data.second_end_x;
      box1.x2hi <= (in_data.second_start_x < in_data.second_end_x) ?
                   in_data.second_end_x : in_data.second_start_x;
      box1.y2lo <= (in_data.second_start_y < in_data.second_end_y) ?
                   in_data.second_start_y : in_data.second_end_y;
      box1.y2hi <= (in_data.second_start_y < in_data.second_end_y) ?
                   in_data.second_end_y : in_data.second_start_y;
    end
  end

  // stage 2: products for c and the determinant
  logic v2;
  logic signed [2*CW-1:0] mc1a, mc1b, mc2a, mc2b;
  logic signed [2*AW-1:0] md1, md2;
  logic signed [AW-1:0] a1_2, b1_2, a2_2, b2_2;
  box_t box2;
  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      mc1a <= p1.first_end_x * p1.first_start_y;
      mc1b <= p1.first_start_x * p1.first_end_y;
      mc2a <= p1.second_end_x * p1.second_start_y;
      mc2b <= p1.second_start_x * p1.second_end_y;
      md1  <= a1_1 * b2_1;
      md2  <= a2_1 * b1_1;
      a1_2 <= a1_1;
      b1_2 <= b1_1;
      a2_2 <= a2_1;
      b2_2 <= b2_1;
      box2 <= box1;
    end
  end

  // stage 3: c1, c2 and determinant
  logic v3;
  logic signed [CPW-1:0] c1_3, c2_3;
  logic signed [DENW-1:0] den3;
  logic signed [AW-1:0] a1_3, b1_3, a2_3, b2_3;
  box_t box3;
  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= v2;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      c1_3 <= CPW'(mc1a) - CPW'(mc1b);
      c2_3 <= CPW'(mc2a) - CPW'(mc2b);
      den3 <= DENW'(md1) - DENW'(md2);
      a1_3 <= a1_2;
      b1_3 <= b1_2;
      a2_3 <= a2_2;
      b2_3 <= b2_2;
      box3 <= box2;
    end
  end

  // stage 4: numerator products
  logic v4;
  logic signed [PW-1:0] pxa, pxb, pya, pyb;
  logic signed [DENW-1:0] den4;
  box_t box4;
  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (en) begin
      v4 <= v3;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      pxa  <= b1_3 * c2_3;
      pxb  <= b2_3 * c1_3;
      pya  <= c1_3 * a2_3;
      pyb  <= c2_3 * a1_3;
      den4 <= den3;
      box4 <= box3;
    end
  end

  // stage 5: numerators and parallel-line flag
  logic v5;
  logic signed [NUMW-1:0] nx5, ny5;
  logic signed [DENW-1:0] den5;
  logic dz5;
  box_t box5;
  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else if (en) begin
      v5 <= v4;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      nx5  <= NUMW'(pxa) - NUMW'(pxb);
      ny5  <= NUMW'(pya) - NUMW'(pyb);
      den5 <= den4;
      dz5  <= (den4 == '0);
      box5 <= box4;
    end
  end

  // stage 6: magnitudes and quotient signs
  logic v6;
  logic [NUMW-1:0] unx6, uny6;
  logic [DENW-1:0] ud6;
  logic negx6, negy6, dz6;
  box_t box6;
  always_ff @(posedge clk) begin
    if (rst) begin
      v6 <= 1'b0;
    end else if (en) begin
      v6 <= v5;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      unx6  <= nx5[NUMW-1] ? NUMW'(-nx5) : NUMW'(nx5);
      uny6  <= ny5[NUMW-1] ? NUMW'(-ny5) : NUMW'(ny5);
      ud6   <= den5[DENW-1] ? DENW'(-den5) : DENW'(den5);
      negx6 <= nx5[NUMW-1] ^ den5[DENW-1];
      negy6 <= ny5[NUMW-1] ^ den5[DENW-1];
      dz6   <= dz5;
      box6  <= box5;
    end
  end

  // stage 7: quotient overflow check and divider setup
  logic [QB:0] dv;
  dstage_t ds [QB+1];
  logic ovfx, ovfy;
  assign ovfx = (DENW+QB)'(unx6) >= {ud6, {QB{1'b0}}};
  assign ovfy = (DENW+QB)'(uny6) >= {ud6, {QB{1'b0}}};
  always_ff @(posedge clk) begin
    if (rst) begin
      dv[0] <= 1'b0;
    end else if (en) begin
      dv[0] <= v6;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      ds[0].rx   <= RW'(unx6[NUMW-1:QB]);
      ds[0].ry   <= RW'(uny6[NUMW-1:QB]);
      ds[0].lx   <= unx6[QB-1:0];
      ds[0].ly   <= uny6[QB-1:0];
      ds[0].qx   <= '0;
      ds[0].qy   <= '0;
      ds[0].ud   <= ud6;
      ds[0].negx <= negx6;
      ds[0].negy <= negy6;
      ds[0].bad  <= dz6 || ovfx || ovfy;
      ds[0].box  <= box6;
    end
  end

  // divider stages, one quotient bit each
  for (genvar k = 0; k < QB; k++) begin : g_div
    always_ff @(posedge clk) begin
      if (rst) begin
        dv[k+1] <= 1'b0;
      end else if (en) begin
        dv[k+1] <= dv[k];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        ds[k+1] <= div_step(ds[k]);
      end
    end
  end

  // sign fix: floor rounding for negative quotients
  logic vf;
  logic signed [BW-1:0] qxf, qyf;
  logic badf;
  box_t boxf;
  logic signed [BW-1:0] qx_pos, qy_pos;
  assign qx_pos = $signed({1'b0, ds[QB].qx});
  assign qy_pos = $signed({1'b0, ds[QB].qy});
  always_ff @(posedge clk) begin
    if (rst) begin
      vf <= 1'b0;
    end else if (en) begin
      vf <= dv[QB];
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      qxf  <= ds[QB].negx ? (-qx_pos - BW'(ds[QB].rx != '0)) : qx_pos;
      qyf  <= ds[QB].negy ? (-qy_pos - BW'(ds[QB].ry != '0)) : qy_pos;
      badf <= ds[QB].bad;
      boxf <= ds[QB].box;
    end
  end

  // range and bounding box checks, output register
  logic hit_c;
  logic signed [CW-1:0] cmin, cmax;
  assign cmin  = {1'b1, {(CW-1){1'b0}}};
  assign cmax  = {1'b0, {(CW-1){1'b1}}};
  assign hit_c = !badf &&
                 in_span(qxf, boxf.x1lo, boxf.x1hi, tolerance) &&
                 in_span(qyf, boxf.y1lo, boxf.y1hi, tolerance) &&
                 in_span(qxf, boxf.x2lo, boxf.x2hi, tolerance) &&
                 in_span(qyf, boxf.y2lo, boxf.y2hi, tolerance) &&
                 in_span(qxf, cmin, cmax, '0) &&
                 in_span(qyf, cmin, cmax, '0);
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= vf;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      out_data.hit     <= hit_c;
      out_data.cross_x <= hit_c ? qxf[CW-1:0] : '0;
      out_data.cross_y <= hit_c ? qyf[CW-1:0] : '0;
    end
  end

endmodule
`default_nettype wire

FILE: dv/segment_intersection_test.sv
// self-checking testbench for the segment intersection block
`timescale 1ns / 1ps
module segment_intersection_test;
  import segint_pkg::*;

  logic            clk = 1'b0;
  logic            rst = 1'b1;
  logic            cfg_we = 1'b0;
  logic [TOLW-1:0] cfg_wdata = '0;
  logic            in_valid = 1'b0;
  logic            in_ready;
  in_t             in_data = '0;
  logic            out_valid;
  logic            out_ready = 1'b0;
  out_t            out_data;

  out_t            pending_crossings[$];
  logic [TOLW-1:0] tol_model = TOL_RESET;
  int              send_idle_pct = 0;
  int              recv_stall_pct = 0;
  int              error_count = 0;

  segment_intersection dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  always #4 clk = ~clk;

  // floor division, d nonzero
  function automatic longint floor_div(longint n, longint d);
    longint q;
    q = n / d;
    if ((n % d != 0) && ((n < 0) != (d < 0))) q = q - 1;
    return q;
  endfunction

  function automatic logic in_bounds(longint p, longint e1, longint e2, longint slack);
    longint lo;
    longint hi;
    lo = ((e1 < e2) ? e1 : e2) - slack;
    hi = ((e1 < e2) ? e2 : e1) + slack;
    return (p >= lo) && (p <= hi);
  endfunction

  // expected crossing for one segment pair
  function automatic out_t predict_crossing(in_t s, logic [TOLW-1:0] tol);
    longint x1, y1, x2, y2, x3, y3, x4, y4;
    longint a1, b1, c1, a2, b2, c2, den, xm, ym, t;
    out_t r;
    x1 = s.first_start_x;  y1 = s.first_start_y;
    x2 = s.first_end_x;    y2 = s.first_end_y;
    x3 = s.second_start_x; y3 = s.second_start_y;
    x4 = s.second_end_x;   y4 = s.second_end_y;
    t  = tol;
    a1 = y2 - y1; b1 = x1 - x2; c1 = x2 * y1 - x1 * y2;
    a2 = y4 - y3; b2 = x3 - x4; c2 = x4 * y3 - x3 * y4;
    den = a1 * b2 - a2 * b1;
    r = '0;
    if (den != 0) begin
      xm = floor_div(b1 * c2 - b2 * c1, den);
      ym = floor_div(c1 * a2 - c2 * a1, den);
      if (in_bounds(xm, x1, x2, t) && in_bounds(ym, y1, y2, t) &&
          in_bounds(xm, x3, x4, t) && in_bounds(ym, y3, y4, t) &&
          in_bounds(xm, -32768, 32767, 0) && in_bounds(ym, -32768, 32767, 0)) begin
        r.hit = 1'b1;
        r.cross_x = xm[CW-1:0];
        r.cross_y = ym[CW-1:0];
      end
    end
    return r;
  endfunction

  function automatic in_t make_pair(longint x1, longint y1, longint x2, longint y2,
                                    longint x3, longint y3, longint x4, longint y4);
    in_t s;
    s.first_start_x = x1[CW-1:0];  s.first_start_y = y1[CW-1:0];
    s.first_end_x = x2[CW-1:0];    s.first_end_y = y2[CW-1:0];
    s.second_start_x = x3[CW-1:0]; s.second_start_y = y3[CW-1:0];
    s.second_end_x = x4[CW-1:0];   s.second_end_y = y4[CW-1:0];
    return s;
  endfunction

  function automatic longint rnd_span(int m);
    return longint'($urandom_range(2 * m)) - m;
  endfunction

  // random pair: mostly crossings, some parallel, shared ends and raw noise
  function automatic in_t random_pair();
    longint px, py, dx1, dy1, dx2, dy2, k1, k2;
    int m;
    in_t s;
    px = rnd_span(14000); py = rnd_span(14000);
    m = ($urandom_range(1)) ? 200 : 4000;
    dx1 = rnd_span(m); dy1 = rnd_span(m); dx2 = rnd_span(m); dy2 = rnd_span(m);
    k1 = $urandom_range(3); k2 = $urandom_range(3);
    case ($urandom_range(9))
      0, 1: s = in_t'({$urandom, $urandom, $urandom, $urandom});
      2: s = make_pair(px, py, px + dx1, py + dy1, px + dx2, py + dy2,
                       px + dx2 + 2 * dx1, py + dy2 + 2 * dy1);
      3: s = make_pair(px - dx1, py - dy1, px + dx1, py + dy1,
                       px + dx1, py + dy1, px + dx2, py + dy2);
      default: s = make_pair(px - k1 * dx1, py - k1 * dy1, px + dx1, py + dy1,
                             px - dx2, py - dy2, px + k2 * dx2, py + k2 * dy2);
    endcase
    return s;
  endfunction

  // send one item, holding valid until accepted
  task automatic send_pair(in_t s);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= s;
    do @(posedge clk); while (!in_ready);
    pending_crossings.push_back(predict_crossing(s, tol_model));
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_crossings.size() != 0) @(negedge clk);
    repeat (30) @(negedge clk);
  endtask

  task automatic set_tolerance(logic [TOLW-1:0] v);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we    <= 1'b0;
    tol_model = v;
  endtask

  // extremes, degenerate and parallel lines, plain crossings
  task automatic test_directed();
    send_pair(make_pair(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768));
    send_pair(make_pair(32767, 32767, 32767, 32767, -32768, -32768, -32768, -32768));
    send_pair(make_pair(-32768, 0, 32767, 0, 0, -32768, 0, 32767));
    send_pair(make_pair(0, 0, 0, 0, -100, -100, 100, 100));
    send_pair(make_pair(0, 0, 100, 100, 10, 0, 110, 100));
    send_pair(make_pair(0, 0, 100, 100, 200, 200, 300, 300));
    send_pair(make_pair(-256, -256, 256, 256, -256, 256, 256, -256));
    send_pair(make_pair(0, 0, 100, 0, 101, -50, 101, 50));
    send_pair(make_pair(0, 0, 100, 0, 102, -50, 102, 50));
    send_pair(make_pair(0, 0, 3, 1, 0, 1, 3, 0));
    send_pair(make_pair(0, 0, -3, 1, 0, 1, -3, 0));
    send_pair(in_t'({8{16'h8000}}));
    send_pair(in_t'({8{16'h7fff}}));
    send_pair(in_t'({4{32'h7fff8000}}));
    send_pair(in_t'({4{32'h80007fff}}));
  endtask

  // wide and zero tolerance at a segment end; a crossing just past the coordinate range still misses
  task automatic test_wide_tolerance();
    set_tolerance(8'hff);
    send_pair(make_pair(32000, 0, 32767, 0, 32766, -200, 32767, -100));
    send_pair(make_pair(0, 0, 100, 0, 355, -50, 355, 50));
    send_pair(make_pair(0, 0, 100, 0, 356, -50, 356, 50));
    set_tolerance(8'h00);
    send_pair(make_pair(0, 0, 100, 0, 100, -50, 100, 50));
    send_pair(make_pair(0, 0, 100, 0, 101, -50, 101, 50));
  endtask

  task automatic test_random(int count, int idle_pct, int stall_pct, logic [TOLW-1:0] tol);
    set_tolerance(tol);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (count) send_pair(random_pair());
  endtask

  // receiver back-pressure
  always @(negedge clk) out_ready <= ($urandom_range(99) >= recv_stall_pct);

  // compare each result with the oldest expectation
  always @(posedge clk) begin
    out_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_crossings.size() == 0) begin
        $display("%0t: unexpected item %h", $time, out_data);
        error_count++;
      end else begin
        want = pending_crossings.pop_front();
        if (out_data.hit !== want.hit) begin
          $display("%0t: hit expected %b actual %b", $time, want.hit, out_data.hit);
          error_count++;
        end
        if (out_data.cross_x !== want.cross_x) begin
          $display("%0t: cross_x expected %0d actual %0d", $time, want.cross_x,
                   out_data.cross_x);
          error_count++;
        end
        if (out_data.cross_y !== want.cross_y) begin
          $display("%0t: cross_y expected %0d actual %0d", $time, want.cross_y,
                   out_data.cross_y);
          error_count++;
        end
      end
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_directed();
    test_wide_tolerance();
    test_random(150, 0, 0, 8'd1);
    test_random(150, 68, 0, 8'hff);
    test_random(150, 0, 68, 8'h00);
    test_random(150, 6, 6, 8'($urandom_range(2, 254)));
    drain();
    if (pending_crossings.size() == 0 && error_count == 0) begin
      $display("segment_intersection verification clean");
    end else begin
      $display("segment_intersection verification failed");
    end
    $finish;
  end

  // watchdog
  initial begin
    #10_000_000;
    $display("segment_intersection verification failed");
    $finish;
  end

endmodule

FILE: sim.f
rtl/core/segint_pkg.sv
rtl/core/segment_intersection.sv
dv/segment_intersection_test.sv
